// File: hdl/abkf_pkg.sv
`timescale 1ns / 1ps
// abkf_pkg: shared types, op and operand codes, saturation and the step table
// for the angle/bias Kalman filter. No dependencies.
package abkf_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int WORD_BITS  = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
  localparam int FRAC_COV   = 24;
  localparam int CFG_BITS   = 31;
  localparam int IDX_BITS   = 3;

  typedef logic signed [31:0] word_t;
  typedef logic [CFG_BITS-1:0] cfg_word_t;
  typedef logic [IDX_BITS-1:0] cfg_idx_t;

  localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (WORD_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

  // register indexes
  localparam cfg_idx_t REG_ANGLE_NOISE = 3'd0;
  localparam cfg_idx_t REG_BIAS_NOISE  = 3'd1;
  localparam cfg_idx_t REG_MEAS_NOISE  = 3'd2;
  localparam cfg_idx_t REG_TIME_STEP   = 3'd3;

  localparam cfg_word_t RST_ANGLE_NOISE = 31'd16777;
  localparam cfg_word_t RST_BIAS_NOISE  = 31'd50331;
  localparam cfg_word_t RST_MEAS_NOISE  = 31'd503316;
  localparam cfg_word_t RST_TIME_STEP   = 31'd167772;

  // shared unit ops
  typedef logic [1:0] op_t;
  localparam op_t OP_ADD = 2'd0;
  localparam op_t OP_SUB = 2'd1;
  localparam op_t OP_MUL = 2'd2;
  localparam op_t OP_DIV = 2'd3;

  // operand / destination codes
  typedef logic [4:0] src_t;
  localparam src_t SRC_Z     = 5'd0;
  localparam src_t SRC_W     = 5'd1;
  localparam src_t SRC_DT    = 5'd2;
  localparam src_t SRC_QA    = 5'd3;
  localparam src_t SRC_QB    = 5'd4;
  localparam src_t SRC_RM    = 5'd5;
  localparam src_t SRC_AE    = 5'd6;
  localparam src_t SRC_BE    = 5'd7;
  localparam src_t SRC_P00   = 5'd8;
  localparam src_t SRC_P01   = 5'd9;
  localparam src_t SRC_P10   = 5'd10;
  localparam src_t SRC_P11   = 5'd11;
  localparam src_t SRC_RATE  = 5'd12;
  localparam src_t SRC_T     = 5'd13;
  localparam src_t SRC_DP11  = 5'd14;
  localparam src_t SRC_Y     = 5'd15;
  localparam src_t SRC_S     = 5'd16;
  localparam src_t SRC_K0    = 5'd17;
  localparam src_t SRC_K1    = 5'd18;

  typedef struct packed {
    op_t  op;
    src_t sa;
    src_t sb;
    src_t dst;
  } uop_t;

  typedef struct packed {
    op_t   op;
    word_t a;
    word_t b;
  } alu_req_t;

  typedef struct packed {
    logic  start;
    word_t num;
    word_t den;
  } div_req_t;

  typedef struct packed {
    logic  done;
    word_t quot;
  } div_rsp_t;

  localparam int STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;
  localparam step_t LAST_STEP = 5'd28;

  function automatic word_t sat_word(input logic signed [63:0] v);
    word_t r;
    if (v > SAT_HI) r = 32'(SAT_HI);
    else if (v < SAT_LO) r = 32'(SAT_LO);
    else r = 32'(v);
    return r;
  endfunction

  // predict, correct, then covariance update (old P00/P01 used before overwrite)
  function automatic uop_t ucode(input step_t step);
    uop_t u;
    unique case (step)
      5'd0:    u = '{OP_SUB, SRC_W,    SRC_BE,   SRC_RATE};
      5'd1:    u = '{OP_MUL, SRC_DT,   SRC_RATE, SRC_T};
      5'd2:    u = '{OP_ADD, SRC_AE,   SRC_T,    SRC_AE};
      5'd3:    u = '{OP_MUL, SRC_DT,   SRC_P11,  SRC_DP11};
      5'd4:    u = '{OP_SUB, SRC_DP11, SRC_P01,  SRC_T};
      5'd5:    u = '{OP_SUB, SRC_T,    SRC_P10,  SRC_T};
      5'd6:    u = '{OP_ADD, SRC_T,    SRC_QA,   SRC_T};
      5'd7:    u = '{OP_MUL, SRC_DT,   SRC_T,    SRC_T};
      5'd8:    u = '{OP_ADD, SRC_P00,  SRC_T,    SRC_P00};
      5'd9:    u = '{OP_SUB, SRC_P01,  SRC_DP11, SRC_P01};
      5'd10:   u = '{OP_SUB, SRC_P10,  SRC_DP11, SRC_P10};
      5'd11:   u = '{OP_MUL, SRC_QB,   SRC_DT,   SRC_T};
      5'd12:   u = '{OP_ADD, SRC_P11,  SRC_T,    SRC_P11};
      5'd13:   u = '{OP_SUB, SRC_Z,    SRC_AE,   SRC_Y};
      5'd14:   u = '{OP_ADD, SRC_P00,  SRC_RM,   SRC_S};
      5'd15:   u = '{OP_DIV, SRC_P00,  SRC_S,    SRC_K0};
      5'd16:   u = '{OP_DIV, SRC_P10,  SRC_S,    SRC_K1};
      5'd17:   u = '{OP_MUL, SRC_K0,   SRC_Y,    SRC_T};
      5'd18:   u = '{OP_ADD, SRC_AE,   SRC_T,    SRC_AE};
      5'd19:   u = '{OP_MUL, SRC_K1,   SRC_Y,    SRC_T};
      5'd20:   u = '{OP_ADD, SRC_BE,   SRC_T,    SRC_BE};
      5'd21:   u = '{OP_MUL, SRC_K1,   SRC_P00,  SRC_T};
      5'd22:   u = '{OP_SUB, SRC_P10,  SRC_T,    SRC_P10};
      5'd23:   u = '{OP_MUL, SRC_K1,   SRC_P01,  SRC_T};
      5'd24:   u = '{OP_SUB, SRC_P11,  SRC_T,    SRC_P11};
      5'd25:   u = '{OP_MUL, SRC_K0,   SRC_P00,  SRC_T};
      5'd26:   u = '{OP_SUB, SRC_P00,  SRC_T,    SRC_P00};
      5'd27:   u = '{OP_MUL, SRC_K0,   SRC_P01,  SRC_T};
      5'd28:   u = '{OP_SUB, SRC_P01,  SRC_T,    SRC_P01};
      default: u = '{OP_ADD, SRC_Z,    SRC_Z,    SRC_T};
    endcase
    return u;
  endfunction

endpackage

// File: hdl/abkf_in_if.sv
`timescale 1ns / 1ps
// abkf_in_if: input word channel (measured angle and gyro rate).
// Depends on abkf_pkg.
interface abkf_in_if;
  logic            valid;
  logic            ready;
  abkf_pkg::word_t measured_angle;
  abkf_pkg::word_t measured_rate;

  modport source (output valid, output measured_angle, output measured_rate, input ready);
  modport sink   (input valid, input measured_angle, input measured_rate, output ready);
endinterface

// File: hdl/abkf_out_if.sv
`timescale 1ns / 1ps
// abkf_out_if: result word channel (filtered angle and corrected rate).
// Depends on abkf_pkg.
interface abkf_out_if;
  logic            valid;
  logic            ready;
  abkf_pkg::word_t filtered_angle;
  abkf_pkg::word_t corrected_rate;

  modport source (output valid, output filtered_angle, output corrected_rate, input ready);
  modport sink   (input valid, input filtered_angle, input corrected_rate, output ready);
endinterface

// File: hdl/abkf_cfg_if.sv
`timescale 1ns / 1ps
// abkf_cfg_if: register write channel, index plus write data.
// Depends on abkf_pkg.
interface abkf_cfg_if;
  logic               valid;
  logic               ready;
  abkf_pkg::cfg_idx_t reg_index;
  logic [31:0]        wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// File: hdl/abkf_alu.sv
`timescale 1ns / 1ps
// abkf_alu: shared saturating add/sub and Q8.24 rounding multiply, registered output.
// Depends on abkf_pkg.
module abkf_alu (
  input  logic               clk,
  input  abkf_pkg::alu_req_t req,
  output abkf_pkg::word_t    result
);
  import abkf_pkg::*;

  logic signed [63:0] a_ext;
  logic signed [63:0] b_ext;
  logic signed [63:0] prod;
  logic signed [63:0] rnd;
  word_t              y;

  assign a_ext = 64'(req.a);
  assign b_ext = 64'(req.b);
  assign prod  = req.a * req.b;
  assign rnd   = (prod + (64'sd1 <<< (FRAC_COV - 1))) >>> FRAC_COV;

  always_comb begin
    case (req.op)
      OP_ADD:  y = sat_word(a_ext + b_ext);
      OP_SUB:  y = sat_word(a_ext - b_ext);
      OP_MUL:  y = sat_word(rnd);
      default: y = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    result <= y;
  end

endmodule

// File: hdl/abkf_div.sv
`timescale 1ns / 1ps
// abkf_div: gain divider, sat((num << 24) / den) truncated toward zero, zero for a zero
// den, one quotient bit a cycle. Depends on abkf_pkg.
module abkf_div (
  input  logic               clk,
  input  logic               rst,
  input  abkf_pkg::div_req_t req,
  output abkf_pkg::div_rsp_t rsp
);
  import abkf_pkg::*;

  logic        busy;
  logic [5:0]  cnt;
  logic [31:0] rem;
  logic [31:0] dvd;
  logic [31:0] dn;
  logic [31:0] q;
  logic        neg;
  logic        done;
  word_t       quot;

  logic [31:0] num_mag;
  logic [31:0] den_mag;
  logic [33:0] trial;
  logic signed [63:0] q_signed;

  assign num_mag  = req.num[31] ? 32'(-{1'b0, req.num}) : req.num;
  assign den_mag  = req.den[31] ? 32'(-{1'b0, req.den}) : req.den;
  assign trial    = {1'b0, rem, dvd[31]} - {2'b0, dn};
  assign q_signed = neg ? -signed'({32'b0, q}) : signed'({32'b0, q});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (busy) begin
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
          quot <= sat_word(q_signed);
        end else begin
          done <= 1'b0;
          cnt <= cnt - 6'd1;
          dvd <= {dvd[30:0], 1'b0};
          if (!trial[33]) begin
            rem <= trial[31:0];
            q   <= {q[30:0], 1'b1};
          end else begin
            rem <= {rem[30:0], dvd[31]};
            q   <= {q[30:0], 1'b0};
          end
        end
      end else if (req.start) begin
        neg <= req.num[31] ^ req.den[31];
        dn  <= den_mag;
        q   <= '0;
        if (den_mag == 32'd0) begin
          done <= 1'b1;
          quot <= '0;
        end else if ({8'b0, num_mag} >= {den_mag, 8'b0}) begin
          // quotient of 2^32 or more
          done <= 1'b1;
          quot <= (req.num[31] ^ req.den[31]) ? 32'(SAT_LO) : 32'(SAT_HI);
        end else begin
          done <= 1'b0;
          busy <= 1'b1;
          cnt  <= 6'd32;
          rem  <= {8'b0, num_mag[31:8]};
          dvd  <= {num_mag[7:0], 24'b0};
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

// File: hdl/angle_bias_kalman_filter.sv
`timescale 1ns / 1ps
// angle_bias_kalman_filter: angle/bias Kalman filter sequencer and state; uses abkf_pkg,
// the abkf interfaces, abkf_alu and abkf_div.
// Each input word runs 27 add/sub/multiply steps on the ALU and 2 gain divisions;
// a division with zero variance or a gain past 32 bits skips the bit iterations.
// A new word is accepted only after the last result word is loaded.
// Reset (rst, synchronous): estimates and covariance clear, registers take defaults.
module angle_bias_kalman_filter (
  input logic       clk,
  input logic       rst,
  abkf_in_if.sink   sample,
  abkf_out_if.source result,
  abkf_cfg_if.sink  cfg
);
  import abkf_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0] state;
  step_t      step;
  logic       out_valid;
  word_t      out_angle;
  word_t      out_rate;

  cfg_word_t angle_process_noise;
  cfg_word_t bias_process_noise;
  cfg_word_t measurement_noise;
  cfg_word_t time_step;

  word_t ae, be, p00, p01, p10, p11;
  word_t z, w, rate, tmp, dp11, innov, s_var, k0, k1;

  uop_t     cur;
  word_t    opa, opb;
  word_t    dt, qa, qb, rm;
  word_t    alu_y;
  word_t    res;
  logic     res_ok;
  alu_req_t alu_req;
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic     load_out;

  assign dt = sat_word(signed'({33'b0, time_step}));
  assign qa = sat_word(signed'({33'b0, angle_process_noise}));
  assign qb = sat_word(signed'({33'b0, bias_process_noise}));
  assign rm = sat_word(signed'({33'b0, measurement_noise}));

  assign cur = ucode(step);

  always_comb begin
    case (cur.sa)
      SRC_Z:    opa = z;
      SRC_W:    opa = w;
      SRC_DT:   opa = dt;
      SRC_QA:   opa = qa;
      SRC_QB:   opa = qb;
      SRC_RM:   opa = rm;
      SRC_AE:   opa = ae;
      SRC_BE:   opa = be;
      SRC_P00:  opa = p00;
      SRC_P01:  opa = p01;
      SRC_P10:  opa = p10;
      SRC_P11:  opa = p11;
      SRC_RATE: opa = rate;
      SRC_T:    opa = tmp;
      SRC_DP11: opa = dp11;
      SRC_Y:    opa = innov;
      SRC_S:    opa = s_var;
      SRC_K0:   opa = k0;
      SRC_K1:   opa = k1;
      default:  opa = '0;
    endcase
    case (cur.sb)
      SRC_Z:    opb = z;
      SRC_W:    opb = w;
      SRC_DT:   opb = dt;
      SRC_QA:   opb = qa;
      SRC_QB:   opb = qb;
      SRC_RM:   opb = rm;
      SRC_AE:   opb = ae;
      SRC_BE:   opb = be;
      SRC_P00:  opb = p00;
      SRC_P01:  opb = p01;
      SRC_P10:  opb = p10;
      SRC_P11:  opb = p11;
      SRC_RATE: opb = rate;
      SRC_T:    opb = tmp;
      SRC_DP11: opb = dp11;
      SRC_Y:    opb = innov;
      SRC_S:    opb = s_var;
      SRC_K0:   opb = k0;
      SRC_K1:   opb = k1;
      default:  opb = '0;
    endcase
  end

  assign alu_req.op  = cur.op;
  assign alu_req.a   = opa;
  assign alu_req.b   = opb;
  assign div_req.start = (state == ST_ISSUE) && (cur.op == OP_DIV);
  assign div_req.num   = opa;
  assign div_req.den   = opb;

  abkf_alu u_alu (
    .clk    (clk),
    .req    (alu_req),
    .result (alu_y)
  );

  abkf_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign res    = (cur.op == OP_DIV) ? div_rsp.quot : alu_y;
  assign res_ok = (state == ST_WAIT) && ((cur.op != OP_DIV) || div_rsp.done);

  assign load_out = (state == ST_DONE) && (!out_valid || result.ready);

  assign sample.ready = (state == ST_IDLE);
  assign cfg.ready    = 1'b1;

  assign result.valid          = out_valid;
  assign result.filtered_angle = out_angle;
  assign result.corrected_rate = out_rate;

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) out_valid <= 1'b1;
      else if (result.valid && result.ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (sample.valid) begin
            state <= ST_ISSUE;
            step  <= '0;
          end
        end
        ST_ISSUE: state <= ST_WAIT;
        ST_WAIT: begin
          if (res_ok) begin
            if (step == LAST_STEP) begin
              state <= ST_DONE;
            end else begin
              state <= ST_ISSUE;
              step  <= step + step_t'(1);
            end
          end
        end
        ST_DONE: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_angle <= ae;
      out_rate  <= rate;
    end
    if (sample.valid && sample.ready) begin
      z <= sample.measured_angle;
      w <= sample.measured_rate;
    end
  end

  // filter state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      ae  <= '0;
      be  <= '0;
      p00 <= '0;
      p01 <= '0;
      p10 <= '0;
      p11 <= '0;
      angle_process_noise <= RST_ANGLE_NOISE;
      bias_process_noise  <= RST_BIAS_NOISE;
      measurement_noise   <= RST_MEAS_NOISE;
      time_step           <= RST_TIME_STEP;
    end else begin
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.reg_index)
          REG_ANGLE_NOISE: angle_process_noise <= cfg.wr_data[CFG_BITS-1:0];
          REG_BIAS_NOISE:  bias_process_noise  <= cfg.wr_data[CFG_BITS-1:0];
          REG_MEAS_NOISE:  measurement_noise   <= cfg.wr_data[CFG_BITS-1:0];
          REG_TIME_STEP:   time_step           <= cfg.wr_data[CFG_BITS-1:0];
          default: ;
        endcase
      end
      if (res_ok) begin
        case (cur.dst)
          SRC_AE:  ae  <= res;
          SRC_BE:  be  <= res;
          SRC_P00: p00 <= res;
          SRC_P01: p01 <= res;
          SRC_P10: p10 <= res;
          SRC_P11: p11 <= res;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_ok) begin
      case (cur.dst)
        SRC_RATE: rate  <= res;
        SRC_T:    tmp   <= res;
        SRC_DP11: dp11  <= res;
        SRC_Y:    innov <= res;
        SRC_S:    s_var <= res;
        SRC_K0:   k0    <= res;
        SRC_K1:   k1    <= res;
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> (state == ST_ISSUE) && (step == '0))
    else $error("accepted word did not start the step sequence");

  a_div_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_WAIT) && (cur.op == OP_DIV))
    else $error("divider finished outside a division step");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step <= LAST_STEP)
    else $error("step counter past last step");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    load_out |=> result.valid && (result.corrected_rate == $past(rate))
                 && (result.filtered_angle == $past(ae)))
    else $error("result word not loaded from final state");
`endif

endmodule
